// File: rtl/lea_pkg.sv
// lea_pkg: shared constants, types and a helper function for the lea-128 cipher block
// depends on nothing; imported by every rtl module of the block but lea_ram
`default_nettype none

package lea_pkg;

    localparam int ROUNDS  = 24;
    localparam int WORD_W  = 32;
    localparam int ROW_W   = 4 * WORD_W;
    localparam int RND_W   = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
    localparam int CFG_IDX_W = 3;

    localparam logic CMD_ENC = 1'b0;
    localparam logic CMD_DEC = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD_3 = 3'd3;

    // four words, word 0 in the lowest bits
    typedef logic [3:0][WORD_W-1:0] blk_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_PRIME,
        ST_RUN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } ks_ctrl_t;

    typedef struct packed {
        logic load;
        logic step;
        logic dec;
    } rnd_ctrl_t;

    localparam logic [3:0][WORD_W-1:0] DELTA = {
        32'h78df30ec, 32'h79e27c8a, 32'h44626b02, 32'hc3efe9db
    };

    // rotl(delta[r mod 4], r + j); rotation by zero is the identity
    function automatic logic [WORD_W-1:0] key_const(input logic [RND_W-1:0] r,
                                                    input logic [1:0] j);
        logic [2*WORD_W-1:0] dd;
        logic [5:0]          n;
        logic [1:0]          rq;
        begin
            rq = 2'(r);
            dd = {DELTA[rq], DELTA[rq]};
            n  = 6'(r) + 6'(j);
            return dd[6'd63 - n -: WORD_W];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/lea_block_cipher_top.sv
// lea-128 block cipher: with a valid key schedule a block goes from input transfer through the
// ram read of the first round-key row and the rounds to the result register; the first block
// after a key write runs the key expansion into the round-key ram first; one block at a time,
// no new block is taken before the result is loaded into the output register, one round per cycle
// through the round unit fed by the single read port of the round-key ram
// rst_n (async, active low) clears the key words to zero and marks the schedule stale
`default_nettype none

module lea_block_cipher_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // configuration write port
    input  wire logic                          cfg_we,
    input  wire logic [lea_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lea_pkg::WORD_W-1:0]    cfg_wdata,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [127:0]                  s_tdata,  // data_word_0..data_word_3
    input  wire logic                          s_tuser,  // cmd
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [127:0]                       m_tdata   // result_word_0..result_word_3
);
    import lea_pkg::*;

    state_t             state_reg, state_next;
    logic [RND_W-1:0]   rnd_reg, rnd_next;
    logic [RND_W-1:0]   raddr;
    logic               keys_ready_reg, keys_ready_next;
    logic               cmd_reg;
    blk_t               key_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    blk_t               m_tdata_reg;
    logic               load_out;

    ks_ctrl_t           ks_ctrl;
    rnd_ctrl_t          rnd_ctrl;
    blk_t               ks_row;
    blk_t               rk_row;
    blk_t               x_blk;
    logic               ram_we;
    logic               in_xfer;
    logic               out_xfer;
    logic               last_rnd;
    logic [RND_W-1:0]   start_rnd;
    logic               in_dec;

    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid_reg && m_tready;
    assign in_dec   = (s_tuser == CMD_DEC);
    // decryption walks the round keys backwards
    assign start_rnd = in_dec ? RND_LAST : '0;
    assign last_rnd  = (cmd_reg == CMD_DEC) ? (rnd_reg == '0) : (rnd_reg == RND_LAST);

    // key words; any write marks the schedule stale
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_WORD_0: key_reg[0] <= cfg_wdata;
                REG_KEY_WORD_1: key_reg[1] <= cfg_wdata;
                REG_KEY_WORD_2: key_reg[2] <= cfg_wdata;
                REG_KEY_WORD_3: key_reg[3] <= cfg_wdata;
                default:        ; // writes beyond the key words are dropped
            endcase
        end
    end

    // control sequencer
    always_comb
    begin
        state_next      = state_reg;
        rnd_next        = rnd_reg;
        keys_ready_next = keys_ready_reg;
        raddr           = rnd_reg;
        ram_we          = 1'b0;
        s_tready        = 1'b0;
        load_out        = 1'b0;
        ks_ctrl         = '0;
        rnd_ctrl        = '0;
        rnd_ctrl.dec    = (cmd_reg == CMD_DEC);

        unique case (state_reg)
            ST_IDLE:
            begin
                // ready throughout idle, so a valid input is a transfer
                s_tready      = 1'b1;
                ks_ctrl.load  = 1'b1;
                rnd_ctrl.load = s_tvalid;
                if (s_tvalid)
                begin
                    if (keys_ready_reg)
                    begin
                        rnd_next   = start_rnd;
                        state_next = ST_PRIME;
                    end
                    else
                    begin
                        rnd_next   = '0;
                        state_next = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND:
            begin
                // one round of the schedule written per cycle
                ks_ctrl.step = 1'b1;
                ram_we       = 1'b1;
                if (rnd_reg == RND_LAST)
                begin
                    keys_ready_next = 1'b1;
                    rnd_next        = (cmd_reg == CMD_DEC) ? RND_LAST : '0;
                    state_next      = ST_PRIME;
                end
                else
                begin
                    rnd_next = rnd_reg + 1'b1;
                end
            end
            ST_PRIME:
            begin
                // ram read of the first round key row in flight
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                rnd_ctrl.step = 1'b1;
                if (last_rnd)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    rnd_next = (cmd_reg == CMD_DEC) ? rnd_reg - 1'b1 : rnd_reg + 1'b1;
                    raddr    = rnd_next;
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            keys_ready_next = 1'b0;
        end
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (load_out)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (out_xfer)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rnd_reg        <= '0;
            keys_ready_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rnd_reg        <= rnd_next;
            keys_ready_reg <= keys_ready_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= s_tuser;
        end
        if (load_out)
        begin
            m_tdata_reg <= x_blk;
        end
    end

    // round-key ram, one row of four words per round
    lea_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROUNDS)
    ) u_rk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (rnd_reg),
        .wdata (ROW_W'(ks_row)),
        .raddr (raddr),
        .rdata (rk_row)
    );

    lea_key_sched u_key_sched (
        .clk  (clk),
        .ctrl (ks_ctrl),
        .key  (key_reg),
        .rnd  (rnd_reg),
        .row  (ks_row)
    );

    lea_round_unit u_round (
        .clk  (clk),
        .ctrl (rnd_ctrl),
        .din  (s_tdata),
        .rk   (rk_row),
        .dout (x_blk)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a block arriving with a stale schedule expands the key first
    a_expand_first: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !keys_ready_reg) |=> (state_reg == ST_EXPAND))
        else $error("stale schedule not expanded");

    // a key write always invalidates the schedule
    a_key_stale: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !keys_ready_reg)
        else $error("key write left schedule marked ready");

    // the schedule only becomes ready at the end of expansion
    a_ready_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(keys_ready_reg) |-> ($past(state_reg) == ST_EXPAND))
        else $error("schedule marked ready outside expansion");

    // the last round is followed by the result hand-off
    a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && last_rnd) |=> (state_reg == ST_DONE))
        else $error("round sequence overran");

endmodule

`default_nettype wire

// File: rtl/lea_ram.sv
// lea_ram: generic single-port-write, single-port-read ram with registered read data
// depends on nothing
`default_nettype none

module lea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/lea_key_sched.sv
// lea_key_sched: key schedule datapath, one round of four round-key words per cycle
// depends on lea_pkg
`default_nettype none

module lea_key_sched (
    input  wire logic                    clk,
    input  wire lea_pkg::ks_ctrl_t       ctrl,
    input  wire lea_pkg::blk_t           key,
    input  wire logic [lea_pkg::RND_W-1:0] rnd,
    output lea_pkg::blk_t                row
);
    import lea_pkg::*;

    blk_t t_reg;
    blk_t t_next;
    blk_t sum;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            sum[j] = t_reg[j] + key_const(rnd, 2'(j));
        end
        t_next[0] = {sum[0][30:0], sum[0][31]};
        t_next[1] = {sum[1][28:0], sum[1][31:29]};
        t_next[2] = {sum[2][25:0], sum[2][31:26]};
        t_next[3] = {sum[3][20:0], sum[3][31:21]};
    end

    assign row = t_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            t_reg <= key;
        end
        else if (ctrl.step)
        begin
            t_reg <= t_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lea_round_unit.sv
// lea_round_unit: block state register and one add-rotate-xor round, forward or inverse
// depends on lea_pkg
`default_nettype none

module lea_round_unit (
    input  wire logic               clk,
    input  wire lea_pkg::rnd_ctrl_t ctrl,
    input  wire lea_pkg::blk_t      din,
    input  wire lea_pkg::blk_t      rk,
    output lea_pkg::blk_t           dout
);
    import lea_pkg::*;

    blk_t x_reg;
    blk_t x_next;
    blk_t enc_res;
    blk_t dec_res;
    logic [WORD_W-1:0] a0, a1, a2;
    logic [WORD_W-1:0] d1, d2, d3;

    always_comb
    begin
        // forward round
        a0 = (x_reg[0] ^ rk[0]) + (x_reg[1] ^ rk[1]);
        a1 = (x_reg[1] ^ rk[2]) + (x_reg[2] ^ rk[1]);
        a2 = (x_reg[2] ^ rk[3]) + (x_reg[3] ^ rk[1]);
        enc_res[0] = {a0[22:0], a0[31:23]};
        enc_res[1] = {a1[4:0], a1[31:5]};
        enc_res[2] = {a2[2:0], a2[31:3]};
        enc_res[3] = x_reg[0];

        // inverse round
        d1 = ({x_reg[0][8:0], x_reg[0][31:9]} - (x_reg[3] ^ rk[0])) ^ rk[1];
        d2 = ({x_reg[1][26:0], x_reg[1][31:27]} - (d1 ^ rk[2])) ^ rk[1];
        d3 = ({x_reg[2][28:0], x_reg[2][31:29]} - (d2 ^ rk[3])) ^ rk[1];
        dec_res[0] = x_reg[3];
        dec_res[1] = d1;
        dec_res[2] = d2;
        dec_res[3] = d3;

        x_next = ctrl.dec ? dec_res : enc_res;
    end

    assign dout = x_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            x_reg <= din;
        end
        else if (ctrl.step)
        begin
            x_reg <= x_next;
        end
    end

endmodule

`default_nettype wire
